// ----- rtl/qicp_pkg.sv -----
// shared types and codes for the identification and configuration phase checker
`timescale 1ns / 1ps

package qicp_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_ENTER    = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_START    = 2'd2,
    REQ_COMPLETE = 2'd3
  } req_t;

  // event codes reported with every result item
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_TIMEOUT    = 3'd1,
    EV_EPT        = 3'd2,
    EV_UNEXPECTED = 3'd3,
    EV_WRONG      = 3'd4,
    EV_CONFIG_OK  = 3'd5
  } event_t;

  // packet header codes
  localparam logic [7:0] HDR_ID      = 8'h71;
  localparam logic [7:0] HDR_EXT_ID  = 8'h81;
  localparam logic [7:0] HDR_CONFIG  = 8'h51;
  localparam logic [7:0] HDR_EPT     = 8'h02;
  localparam logic [7:0] HDR_HOLDOFF = 8'h06;

  // configuration register indexes
  localparam logic [2:0] CFG_FIRST_PACKET_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_RECONFIG_TIMEOUT     = 3'd1;
  localparam logic [2:0] CFG_PACKET_MAX_TIME      = 3'd2;
  localparam logic [2:0] CFG_CONFIG_PHASE_TIMEOUT = 3'd3;
  localparam logic [2:0] CFG_HOLDOFF_MIN          = 3'd4;
  localparam logic [2:0] CFG_HOLDOFF_MAX          = 3'd5;

  // register reset values
  localparam logic [15:0] FIRST_PACKET_TIMEOUT_RST = 16'd41;
  localparam logic [15:0] RECONFIG_TIMEOUT_RST     = 16'd191;
  localparam logic [15:0] PACKET_MAX_TIME_RST      = 16'd170;
  localparam logic [15:0] CONFIG_PHASE_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  HOLDOFF_MIN_RST          = 8'd5;
  localparam logic [7:0]  HOLDOFF_MAX_RST          = 8'd205;

  // configuration register set
  typedef struct packed {
    logic [15:0] first_packet_timeout;
    logic [15:0] reconfig_timeout;
    logic [15:0] packet_max_time;
    logic [15:0] config_phase_timeout;
    logic [7:0]  holdoff_min;
    logic [7:0]  holdoff_max;
  } cfg_t;

  // one input item
  typedef struct packed {
    req_t       req_type;
    logic [7:0] header_byte;
    logic [7:0] first_payload;
    logic       reconfigure_entry;
    logic       extended_id_flag;
    logic [7:0] expected_opt_count;
  } item_t;

  // one result item
  typedef struct packed {
    event_t     event_code;
    logic [7:0] event_param;
    logic       holdoff_write;
    logic [7:0] holdoff_value;
  } res_t;

endpackage

// ----- rtl/qi_id_config_phase_checker.sv -----
// top level of the identification and configuration phase checker
`timescale 1ns / 1ps

// Checks the identification and configuration phase of a wireless power
// transmitter. Each input item (enter, tick, packet start, packet complete)
// gives exactly one result item with an event code and an optional new
// hold-off time. Items pass through an input register and a result register
// with one short decision step between them, so the block takes one item
// per clock cycle while the output is not stalled. A result is offered once
// its item has moved from the input register through the decision step
// into the result register. Phase state and both timers update in
// that same step, so consecutive items see each other's effects in order.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// and must only change while no item is in flight.

module qi_id_config_phase_checker import qicp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // header_byte[7:0], first_payload[15:8], reconfigure_entry[16],
  // extended_id_flag[17], expected_opt_count[25:18], zero pad[31:26]
  input  logic [31:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_tuser,
  // result item stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // event_param[7:0], holdoff_write[8], holdoff_value[16:9], zero pad[23:17]
  output logic [23:0] m_tdata,
  // event_code[2:0]
  output logic [2:0]  m_tuser,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  res_t  step_res;
  res_t  out_res;
  logic  out_valid;
  logic  advance;

  qicp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // item moves on when the result register is free or being emptied
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type           <= req_t'(s_tuser);
      in_item.header_byte        <= s_tdata[7:0];
      in_item.first_payload      <= s_tdata[15:8];
      in_item.reconfigure_entry  <= s_tdata[16];
      in_item.extended_id_flag   <= s_tdata[17];
      in_item.expected_opt_count <= s_tdata[25:18];
    end
  end

  qicp_step u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.event_code;
  assign m_tdata  = {7'd0, out_res.holdoff_value, out_res.holdoff_write, out_res.event_param};

  // a hold-off write only comes with no event
  a_holdoff_no_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.holdoff_write |-> out_res.event_code == EV_NONE)
    else $error("hold-off write together with an event");

  // the reason byte is only set on end transfer
  a_param_only_ept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.event_code != EV_EPT |-> out_res.event_param == 8'd0)
    else $error("event parameter set without end transfer");

  // a held input item is not dropped while the output stalls
  a_in_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("input item lost during stall");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid)
    else $error("pipeline not empty after reset");

endmodule

// ----- rtl/qicp_cfg_regs.sv -----
// configuration register file of the phase checker
`timescale 1ns / 1ps

module qicp_cfg_regs import qicp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // write one register per enabled cycle, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_packet_timeout <= FIRST_PACKET_TIMEOUT_RST;
      cfg.reconfig_timeout     <= RECONFIG_TIMEOUT_RST;
      cfg.packet_max_time      <= PACKET_MAX_TIME_RST;
      cfg.config_phase_timeout <= CONFIG_PHASE_TIMEOUT_RST;
      cfg.holdoff_min          <= HOLDOFF_MIN_RST;
      cfg.holdoff_max          <= HOLDOFF_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_PACKET_TIMEOUT: cfg.first_packet_timeout <= cfg_data;
        CFG_RECONFIG_TIMEOUT:     cfg.reconfig_timeout     <= cfg_data;
        CFG_PACKET_MAX_TIME:      cfg.packet_max_time      <= cfg_data;
        CFG_CONFIG_PHASE_TIMEOUT: cfg.config_phase_timeout <= cfg_data;
        CFG_HOLDOFF_MIN:          cfg.holdoff_min          <= cfg_data[7:0];
        CFG_HOLDOFF_MAX:          cfg.holdoff_max          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/qicp_step.sv -----
// phase state, timers and the per-item decision logic
`timescale 1ns / 1ps

module qicp_step import qicp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [7:0]  expected_header, expected_header_next;
  logic        in_id_stage, in_id_stage_next;
  logic        awaiting_first_id, awaiting_first_id_next;
  logic [7:0]  opt_packet_count, opt_packet_count_next;
  logic [15:0] timer_one_count, timer_one_count_next;
  logic        timer_one_running, timer_one_running_next;
  logic [15:0] timer_two_count, timer_two_count_next;
  logic        timer_two_running, timer_two_running_next;

  logic [15:0] t1_dec, t2_dec;
  logic        expired;
  logic        holdoff_bad;
  logic [7:0]  count_inc;

  // tick decrements running timers that are not yet at zero
  always_comb begin
    t1_dec = timer_one_count;
    t2_dec = timer_two_count;
    if (item.req_type == REQ_TICK && timer_one_running && timer_one_count != 16'd0) begin
      t1_dec = timer_one_count - 16'd1;
    end
    if (item.req_type == REQ_TICK && timer_two_running && timer_two_count != 16'd0) begin
      t2_dec = timer_two_count - 16'd1;
    end
  end

  assign expired     = (timer_one_running && t1_dec == 16'd0) ||
                       (timer_two_running && t2_dec == 16'd0);
  assign holdoff_bad = (item.first_payload < cfg.holdoff_min) ||
                       (item.first_payload > cfg.holdoff_max);
  assign count_inc   = opt_packet_count + 8'd1;

  // next state and result for the current item
  always_comb begin
    expected_header_next   = expected_header;
    in_id_stage_next       = in_id_stage;
    awaiting_first_id_next = awaiting_first_id;
    opt_packet_count_next  = opt_packet_count;
    timer_one_count_next   = timer_one_count;
    timer_one_running_next = timer_one_running;
    timer_two_count_next   = timer_two_count;
    timer_two_running_next = timer_two_running;
    res = '{event_code: EV_NONE, event_param: 8'd0, holdoff_write: 1'b0, holdoff_value: 8'd0};

    if (item.req_type == REQ_ENTER) begin
      opt_packet_count_next  = 8'd0;
      timer_one_running_next = 1'b1;
      if (item.reconfigure_entry) begin
        awaiting_first_id_next = 1'b0;
        in_id_stage_next       = 1'b0;
        timer_one_count_next   = cfg.reconfig_timeout;
      end else begin
        timer_one_count_next   = cfg.first_packet_timeout;
        awaiting_first_id_next = 1'b1;
        in_id_stage_next       = 1'b1;
        expected_header_next   = HDR_ID;
        res.holdoff_write      = 1'b1;
        res.holdoff_value      = cfg.holdoff_min;
      end
    end else begin
      timer_one_count_next = t1_dec;
      timer_two_count_next = t2_dec;
      if (expired) begin
        res.event_code = EV_TIMEOUT;
      end else if (item.req_type != REQ_TICK) begin
        // first identification packet arms the packet and phase timers
        if (awaiting_first_id && item.header_byte == HDR_ID) begin
          timer_two_count_next   = cfg.packet_max_time;
          timer_two_running_next = 1'b1;
          awaiting_first_id_next = 1'b0;
          timer_one_count_next   = cfg.config_phase_timeout;
          timer_one_running_next = 1'b1;
        end
        if (item.req_type == REQ_COMPLETE) begin
          timer_two_count_next   = cfg.reconfig_timeout;
          timer_two_running_next = 1'b1;
          priority if (item.header_byte == HDR_EPT) begin
            res.event_code  = EV_EPT;
            res.event_param = item.first_payload;
          end else if (in_id_stage) begin
            // identification stage: headers must come in order
            if (item.header_byte != expected_header) begin
              res.event_code = EV_UNEXPECTED;
            end else if (item.header_byte == HDR_ID) begin
              if (item.extended_id_flag) begin
                expected_header_next = HDR_EXT_ID;
              end else begin
                in_id_stage_next = 1'b0;
              end
            end else if (item.header_byte == HDR_EXT_ID) begin
              in_id_stage_next       = 1'b0;
              timer_one_count_next   = cfg.config_phase_timeout;
              timer_one_running_next = 1'b1;
            end
          end else if (item.header_byte == HDR_HOLDOFF) begin
            if (holdoff_bad) begin
              res.event_code = EV_WRONG;
            end else begin
              opt_packet_count_next = count_inc;
              res.holdoff_write     = 1'b1;
              res.holdoff_value     = item.first_payload;
            end
          end else if (item.header_byte == HDR_CONFIG) begin
            timer_one_running_next = 1'b0;
            timer_one_count_next   = 16'd0;
            res.event_code = (item.expected_opt_count != opt_packet_count) ?
                             EV_WRONG : EV_CONFIG_OK;
          end else if (item.header_byte > HDR_HOLDOFF) begin
            opt_packet_count_next = count_inc;
          end
        end
      end
    end
  end

  // state update when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_header   <= HDR_ID;
      in_id_stage       <= 1'b0;
      awaiting_first_id <= 1'b0;
      opt_packet_count  <= 8'd0;
      timer_one_count   <= 16'd0;
      timer_one_running <= 1'b0;
      timer_two_count   <= 16'd0;
      timer_two_running <= 1'b0;
    end else if (en) begin
      expected_header   <= expected_header_next;
      in_id_stage       <= in_id_stage_next;
      awaiting_first_id <= awaiting_first_id_next;
      opt_packet_count  <= opt_packet_count_next;
      timer_one_count   <= timer_one_count_next;
      timer_one_running <= timer_one_running_next;
      timer_two_count   <= timer_two_count_next;
      timer_two_running <= timer_two_running_next;
    end
  end

endmodule
